[hdl/mwqs_pkg.sv]
package mwqs_pkg;

  localparam int unsigned LINK_W  = 3;
  localparam int unsigned DELAY_W = 32;
  localparam int unsigned MEAN_W  = 40;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned CAP_W   = 6;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned IN_W    = 16;
  localparam int unsigned OUT_W   = 96;
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic KIND_PACKET  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARRIVE,
    S_SELECT,
    S_READ,
    S_START,
    S_DIVIDE,
    S_EMIT,
    S_SUMMARY
  } state_e;

endpackage

[hdl/mwqs_stamp_ram.sv]
module mwqs_stamp_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/mwqs_div.sv]
module mwqs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mwqs_pkg::MEAN_W-1:0]   dividend_i,
  input  logic [mwqs_pkg::COUNT_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [mwqs_pkg::MEAN_W-1:0]   quotient_o,
  output logic                          rem_nz_o
);
  import mwqs_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [MEAN_W-1:0]    quo_q;
  logic [COUNT_W-1:0]   rem_q;
  logic [COUNT_W-1:0]   div_q;
  logic [COUNT_W:0]     trial;
  logic                 ge;

  assign trial = {rem_q, quo_q[MEAN_W-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CNT_W'(MEAN_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? COUNT_W'(trial - {1'b0, div_q}) : trial[COUNT_W-1:0];
      quo_q <= {quo_q[MEAN_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
  assign rem_nz_o   = rem_q != '0;

endmodule

[hdl/max_weight_queue_scheduler.sv]
// channel  | dir | tdata fields (lsb first)                              | tuser | tlast
// s_axis   | in  | arrival_mask[7:0] capacity[13:8]                      | -     | -
// m_axis   | out | link[2:0] packet_delay[34:3] mean_delay[74:35]        | kind  | last
//          |     | dropped_mask[82:75] served_in_tick[88:83]             |       |
// one tick takes an accept step, an arrival pass over the NUM_LINKS links, a selection pass over
// the links per batch and one last selection that ends the tick, plus for each served packet
// a stamp read, a divider start, the bit-serial mean divider and an emit step
// the summary is emitted after that last selection
// reset clears all queues, counts, means and the tick counter; stamp memory is not cleared
// a stalled output holds the block in place; no new tick is taken until the summary is loaded into the output register
module max_weight_queue_scheduler #(
  parameter int unsigned NUM_LINKS    = 8,
  parameter int unsigned QUEUE_DEPTH  = 64,
  parameter int unsigned MAX_CAPACITY = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [mwqs_pkg::IN_W-1:0]   s_axis_tdata_i,  // arrival_mask, capacity
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [mwqs_pkg::OUT_W-1:0]  m_axis_tdata_o,  // link, packet_delay, mean_delay,
                                                       // dropped_mask, served_in_tick
  output logic                        m_axis_tuser_o,  // kind
  output logic                        m_axis_tlast_o
);
  import mwqs_pkg::*;

  localparam int unsigned LW = $clog2(NUM_LINKS);
  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = $clog2(NUM_LINKS * QUEUE_DEPTH);
  localparam int unsigned TW = $clog2(NUM_LINKS * QUEUE_DEPTH + 1);

  state_e state_q, state_d;

  logic [PW-1:0]      head_q   [NUM_LINKS];
  logic [FW-1:0]      fill_q   [NUM_LINKS];
  logic [COUNT_W-1:0] served_q [NUM_LINKS];
  logic [MEAN_W-1:0]  mean_q   [NUM_LINKS];

  logic [DELAY_W-1:0] tick_q;
  logic [NUM_LINKS-1:0] arr_q;
  logic [NUM_LINKS-1:0] drop_q;
  logic [CAP_W-1:0]   cap_q;
  logic [CAP_W-1:0]   k_q;
  logic [CAP_W-1:0]   served_tot_q;
  logic [TW-1:0]      total_q;
  logic [LW-1:0]      idx_q;
  logic [LW-1:0]      best_q;
  logic [FW-1:0]      blen_q;
  logic [MEAN_W-1:0]  bmean_q;
  logic [DELAY_W-1:0] delay_q;
  logic [COUNT_W-1:0] scount_q;
  logic               up_q;

  logic               out_valid_q;
  logic [OUT_W-1:0]   out_data_q;
  logic               out_kind_q;
  logic               out_last_q;
  logic               out_free;

  logic [NUM_LINKS-1:0] mask_in;
  logic [MASK_W-1:0]    drop_out;
  logic [CAP_W-1:0]     cap_in;

  logic [FW:0]        pos_sum;
  logic [PW-1:0]      pos;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [DELAY_W-1:0] ram_rdata;

  logic [DELAY_W-1:0] delay;
  logic [MEAN_W-1:0]  x_val;
  logic [MEAN_W-1:0]  m_best;
  logic               x_ge;
  logic [COUNT_W-1:0] scount_new;
  logic               div_start;
  logic               div_done;
  logic [MEAN_W-1:0]  div_quo;
  logic               div_rem_nz;
  logic [MEAN_W-1:0]  mean_new;
  logic [PW-1:0]      head_next;
  logic               last_link;
  logic [FW-1:0]      fill_i;
  logic [TW-1:0]      fill_after;
  logic [CAP_W-1:0]   cap_sat;

  for (genvar j = 0; j < NUM_LINKS; j++) begin : g_mask
    if (j < MASK_W) begin : g_in
      assign mask_in[j] = s_axis_tdata_i[j];
    end else begin : g_none
      assign mask_in[j] = 1'b0;
    end
  end

  for (genvar j = 0; j < MASK_W; j++) begin : g_drop
    if (j < NUM_LINKS) begin : g_in
      assign drop_out[j] = drop_q[j];
    end else begin : g_none
      assign drop_out[j] = 1'b0;
    end
  end

  assign cap_in  = s_axis_tdata_i[MASK_W +: CAP_W];
  assign cap_sat = (32'(cap_in) > 32'(MAX_CAPACITY)) ? CAP_W'(MAX_CAPACITY) : cap_in;

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign last_link = idx_q == LW'(NUM_LINKS - 1);
  assign fill_i    = fill_q[idx_q];

  // arrival write position
  assign pos_sum   = (FW + 1)'(head_q[idx_q]) + (FW + 1)'(fill_i);
  assign pos       = (32'(pos_sum) >= 32'(QUEUE_DEPTH)) ?
                     PW'(32'(pos_sum) - 32'(QUEUE_DEPTH)) : PW'(pos_sum);
  assign ram_we    = (state_q == S_ARRIVE) && arr_q[idx_q] &&
                     (32'(fill_i) < 32'(QUEUE_DEPTH));
  assign ram_waddr = AW'(AW'(idx_q) * AW'(QUEUE_DEPTH)) + AW'(pos);
  assign ram_raddr = AW'(AW'(best_q) * AW'(QUEUE_DEPTH)) + AW'(head_q[best_q]);
  assign fill_after = TW'(fill_i) + TW'(ram_we);

  mwqs_stamp_ram #(
    .DEPTH(NUM_LINKS * QUEUE_DEPTH),
    .WIDTH(DELAY_W)
  ) u_stamp_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(tick_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // mean update operands
  assign delay      = tick_q - ram_rdata;
  assign x_val      = {delay, {FRAC_W{1'b0}}};
  assign m_best     = mean_q[best_q];
  assign x_ge       = x_val >= m_best;
  assign scount_new = (served_q[best_q] == COUNT_MAX) ? COUNT_MAX : served_q[best_q] + 1'b1;
  assign div_start  = state_q == S_START;

  mwqs_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(x_ge ? x_val - m_best : m_best - x_val),
    .divisor_i (scount_new),
    .done_o    (div_done),
    .quotient_o(div_quo),
    .rem_nz_o  (div_rem_nz)
  );

  assign mean_new  = up_q ? m_best + div_quo : m_best - div_quo - MEAN_W'(div_rem_nz);
  assign head_next = (32'(head_q[best_q]) == 32'(QUEUE_DEPTH - 1)) ? '0 : head_q[best_q] + 1'b1;

  assign s_axis_tready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = S_ARRIVE;
        end
      end
      S_ARRIVE: begin
        if (last_link) begin
          state_d = S_SELECT;
        end
      end
      S_SELECT: begin
        if (cap_q == '0) begin
          state_d = S_SUMMARY;
        end else if (last_link) begin
          if (blen_q == '0 && fill_i == '0) begin
            state_d = S_SUMMARY;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_START;
      end
      S_START: begin
        state_d = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = (k_q == CAP_W'(1)) ? S_SELECT : S_READ;
        end
      end
      S_SUMMARY: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LINKS; i++) begin
        head_q[i]   <= '0;
        fill_q[i]   <= '0;
        served_q[i] <= '0;
        mean_q[i]   <= '0;
      end
      tick_q       <= '0;
      arr_q        <= '0;
      drop_q       <= '0;
      cap_q        <= '0;
      k_q          <= '0;
      served_tot_q <= '0;
      total_q      <= '0;
      idx_q        <= '0;
      best_q       <= '0;
      blen_q       <= '0;
      bmean_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if ((state_q == S_EMIT || state_q == S_SUMMARY) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            arr_q        <= mask_in;
            cap_q        <= cap_sat;
            drop_q       <= '0;
            total_q      <= '0;
            served_tot_q <= '0;
            idx_q        <= '0;
          end
        end
        S_ARRIVE: begin
          if (arr_q[idx_q] && !ram_we) begin
            drop_q[idx_q] <= 1'b1;
          end
          if (ram_we) begin
            fill_q[idx_q] <= fill_i + 1'b1;
          end
          if (last_link) begin
            idx_q  <= '0;
            blen_q <= '0;
            best_q <= '0;
            if (32'(cap_q) > 32'(total_q + fill_after)) begin
              cap_q <= CAP_W'(total_q + fill_after);
            end
          end else begin
            total_q <= total_q + fill_after;
            idx_q   <= idx_q + 1'b1;
          end
        end
        S_SELECT: begin
          if (fill_i > blen_q ||
              (fill_i == blen_q && mean_q[idx_q] > bmean_q && idx_q != '0)) begin
            best_q  <= idx_q;
            blen_q  <= fill_i;
            bmean_q <= mean_q[idx_q];
          end else if (idx_q == '0) begin
            bmean_q <= mean_q[idx_q];
          end
          if (last_link) begin
            idx_q <= '0;
            if (fill_i > blen_q) begin
              k_q <= (32'(fill_i) < 32'(cap_q)) ? CAP_W'(fill_i) : cap_q;
            end else begin
              k_q <= (32'(blen_q) < 32'(cap_q)) ? CAP_W'(blen_q) : cap_q;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_START: begin
          delay_q  <= delay;
          scount_q <= scount_new;
          up_q     <= x_ge;
        end
        S_EMIT: begin
          if (out_free) begin
            head_q[best_q]   <= head_next;
            fill_q[best_q]   <= fill_q[best_q] - 1'b1;
            served_q[best_q] <= scount_q;
            mean_q[best_q]   <= mean_new;
            k_q              <= k_q - 1'b1;
            cap_q            <= cap_q - 1'b1;
            served_tot_q     <= served_tot_q + 1'b1;
            if (k_q == CAP_W'(1)) begin
              blen_q <= '0;
              best_q <= '0;
            end
          end
        end
        S_SUMMARY: begin
          if (out_free) begin
            tick_q <= tick_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      out_kind_q <= KIND_PACKET;
      out_last_q <= 1'b0;
      out_data_q <= {7'b0, {CAP_W{1'b0}}, {MASK_W{1'b0}}, mean_new, delay_q, LINK_W'(best_q)};
    end else if (state_q == S_SUMMARY && out_free) begin
      out_kind_q <= KIND_SUMMARY;
      out_last_q <= 1'b1;
      out_data_q <= {7'b0, served_tot_q, drop_out, {MEAN_W{1'b0}}, {DELAY_W{1'b0}},
                     {LINK_W{1'b0}}};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
